/* rtl/vn_pkg.sv */
package vn_pkg;

  // Fixed field widths of the vector and result channels
  localparam int unsigned CompW = 32;
  localparam int unsigned SqW   = 64;

  // Number of vector components, one lane each
  localparam int unsigned NumLanes = 3;

  // Per-lane pipeline control that travels with each vector
  typedef struct packed {
    logic vld;
    logic neg;
  } vn_ctl_t;

endpackage

/* rtl/vector3_normalizer.sv */
// 3D vector normalizer.
// Input channel: in_valid_i / in_stall_o carry one vector (vec_x/y/z_i,
// signed fixed point). A transfer happens when valid is high and stall low.
// Output channel: out_valid_o / out_stall_i carry unit_x/y/z_o (signed,
// OUT_FRAC_BITS fraction bits, rounded to nearest, ties away from zero),
// length_squared_o (exact sum of squared raw components) and zero_length_o.
// Throughput: one vector per cycle while not stalled. Pipeline: magnitude
// and square registers, one setup register, a reciprocal-root search stage
// per result bit in each of the three lanes, and one output register.
// A zero vector returns all-zero units with zero_length_o set.
// Reset clears every valid bit; the pipeline comes up empty.
// While out_stall_i holds a valid result, the whole pipeline freezes and
// in_stall_o is raised; empty slots upstream are not reclaimed.
module vector3_normalizer #(
  parameter int unsigned OUT_FRAC_BITS = 30
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [vn_pkg::CompW-1:0] vec_x_i,
  input  logic signed [vn_pkg::CompW-1:0] vec_y_i,
  input  logic signed [vn_pkg::CompW-1:0] vec_z_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [vn_pkg::CompW-1:0] unit_x_o,
  output logic signed [vn_pkg::CompW-1:0] unit_y_o,
  output logic signed [vn_pkg::CompW-1:0] unit_z_o,
  output logic [vn_pkg::SqW-1:0]          length_squared_o,
  output logic                            zero_length_o
);

  localparam int unsigned FRAC = OUT_FRAC_BITS;
  localparam int unsigned L    = vn_pkg::NumLanes;

  logic                     en;
  logic [vn_pkg::CompW-1:0] comp   [L];
  vn_pkg::vn_ctl_t          sq_ctl [L];
  logic [vn_pkg::SqW-1:0]   sq     [L];
  vn_pkg::vn_ctl_t          ln_ctl [L];
  logic [FRAC:0]            ln_q   [L];
  logic [vn_pkg::SqW-1:0]   ln_s   [L];
  logic [vn_pkg::SqW-1:0]   s_sum;

  logic                     out_vld_q;
  logic [vn_pkg::CompW-1:0] unit_d [L];
  logic [vn_pkg::CompW-1:0] unit_q [L];
  logic [vn_pkg::SqW-1:0]   len_q;
  logic                     zero_d, zero_q;

  // Whole pipeline advances unless a held result is stalled
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  assign comp[0] = vec_x_i;
  assign comp[1] = vec_y_i;
  assign comp[2] = vec_z_i;

  for (genvar i = 0; i < L; i++) begin : g_sq
    vn_square u_sq (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (in_valid_i),
      .comp_i (comp[i]),
      .ctl_o  (sq_ctl[i]),
      .sq_o   (sq[i])
    );
  end

  // Squared length; at most 3*2^62, no overflow
  assign s_sum = sq[0] + sq[1] + sq[2];

  for (genvar i = 0; i < L; i++) begin : g_lane
    vn_lane #(.FRAC(FRAC)) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (sq_ctl[i]),
      .sq_i   (sq[i]),
      .s_i    (s_sum),
      .ctl_o  (ln_ctl[i]),
      .q_o    (ln_q[i]),
      .s_o    (ln_s[i])
    );
  end

  // Merge: clamp, apply sign, zero-vector override
  assign zero_d = (ln_s[0] == '0);

  always_comb begin
    logic [FRAC:0] mag;
    for (int i = 0; i < L; i++) begin
      mag = (ln_q[i] > ((FRAC + 1)'(1) << FRAC)) ? ((FRAC + 1)'(1) << FRAC) : ln_q[i];
      if (zero_d) begin
        unit_d[i] = '0;
      end else if (ln_ctl[i].neg) begin
        unit_d[i] = -vn_pkg::CompW'(mag);
      end else begin
        unit_d[i] = vn_pkg::CompW'(mag);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= ln_ctl[0].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      unit_q <= unit_d;
      len_q  <= ln_s[0];
      zero_q <= zero_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign unit_x_o         = unit_q[0];
  assign unit_y_o         = unit_q[1];
  assign unit_z_o         = unit_q[2];
  assign length_squared_o = len_q;
  assign zero_length_o    = zero_q;

  // Checks
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ln_ctl[0].vld == ln_ctl[1].vld) && (ln_ctl[1].vld == ln_ctl[2].vld))
    else $error("lanes out of step");

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |-> (unit_x_o == '0) && (unit_y_o == '0)
      && (unit_z_o == '0) && (length_squared_o == '0))
    else $error("zero vector with nonzero result");

  a_nonzero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !zero_length_o |-> (length_squared_o != '0))
    else $error("zero flag clear on zero length");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(ln_ctl[0].vld))
    else $error("pipeline moved while stalled");

endmodule

/* rtl/vn_square.sv */
module vn_square (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [vn_pkg::CompW-1:0]  comp_i,
  output vn_pkg::vn_ctl_t           ctl_o,
  output logic [vn_pkg::SqW-1:0]    sq_o
);

  logic                     vld1_q, vld2_q;
  logic                     neg1_q, neg2_q;
  logic [vn_pkg::CompW-1:0] mag_d, mag_q;
  logic [vn_pkg::SqW-1:0]   sq_q;

  // Magnitude; the most negative value maps to 2^31, which still fits
  assign mag_d = comp_i[vn_pkg::CompW-1] ? (~comp_i + vn_pkg::CompW'(1)) : comp_i;

  // Control: valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  // Payload: magnitude, then square
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      neg1_q <= comp_i[vn_pkg::CompW-1];
      sq_q   <= vn_pkg::SqW'(mag_q) * vn_pkg::SqW'(mag_q);
      neg2_q <= neg1_q;
    end
  end

  assign ctl_o.vld = vld2_q;
  assign ctl_o.neg = neg2_q;
  assign sq_o      = sq_q;

endmodule

/* rtl/vn_search_stage.sv */
module vn_search_stage #(
  parameter int unsigned FRAC = 30,
  parameter int unsigned BIT  = 0,
  parameter int unsigned PW   = 2 * FRAC + 70
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  vn_pkg::vn_ctl_t          ctl_i,
  input  logic [FRAC:0]            q_i,
  input  logic signed [PW-1:0]     p_i,
  input  logic signed [PW-1:0]     m_i,
  input  logic signed [PW-1:0]     r_i,
  input  logic [vn_pkg::SqW-1:0]   s_i,
  output vn_pkg::vn_ctl_t          ctl_o,
  output logic [FRAC:0]            q_o,
  output logic signed [PW-1:0]     p_o,
  output logic signed [PW-1:0]     m_o,
  output logic signed [PW-1:0]     r_o,
  output logic [vn_pkg::SqW-1:0]   s_o
);

  // p holds (2q-1)^2*s, m holds (2q-1)*s; setting bit BIT of q adds 2^(BIT+1) to 2q-1
  logic signed [PW-1:0] s_ext, cand;
  logic                 take;
  logic                 vld_q, neg_q;
  logic [FRAC:0]        q_q;
  logic signed [PW-1:0] p_q, m_q, r_q;
  logic [vn_pkg::SqW-1:0] s_q;

  assign s_ext = PW'(s_i);
  assign cand  = p_i + (m_i <<< (BIT + 2)) + (s_ext <<< (2 * BIT + 2));
  assign take  = (cand <= r_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= ctl_i.vld;
    end
  end

  // Trial bit accepted when the candidate stays within the bound
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= ctl_i.neg;
      r_q   <= r_i;
      s_q   <= s_i;
      if (take) begin
        q_q <= q_i | ((FRAC + 1)'(1) << BIT);
        p_q <= cand;
        m_q <= m_i + (s_ext <<< (BIT + 1));
      end else begin
        q_q <= q_i;
        p_q <= p_i;
        m_q <= m_i;
      end
    end
  end

  assign ctl_o.vld = vld_q;
  assign ctl_o.neg = neg_q;
  assign q_o = q_q;
  assign p_o = p_q;
  assign m_o = m_q;
  assign r_o = r_q;
  assign s_o = s_q;

endmodule

/* rtl/vn_lane.sv */
module vn_lane #(
  parameter int unsigned FRAC = 30
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  vn_pkg::vn_ctl_t          ctl_i,
  input  logic [vn_pkg::SqW-1:0]   sq_i,
  input  logic [vn_pkg::SqW-1:0]   s_i,
  output vn_pkg::vn_ctl_t          ctl_o,
  output logic [FRAC:0]            q_o,
  output logic [vn_pkg::SqW-1:0]   s_o
);

  localparam int unsigned PW = 2 * FRAC + 70;
  localparam int unsigned NS = FRAC + 1;

  vn_pkg::vn_ctl_t        ctl_w [NS+1];
  logic [FRAC:0]          q_w   [NS+1];
  logic signed [PW-1:0]   p_w   [NS+1];
  logic signed [PW-1:0]   m_w   [NS+1];
  logic signed [PW-1:0]   r_w   [NS+1];
  logic [vn_pkg::SqW-1:0] s_w   [NS+1];

  logic                   vld_q, neg_q;
  logic signed [PW-1:0]   p_q, m_q, r_q;
  logic [vn_pkg::SqW-1:0] s_q;

  // Setup: start from q = 0, i.e. 2q-1 = -1; bound is a^2 * 4^(FRAC+1)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= ctl_i.neg;
      s_q   <= s_i;
      p_q   <= PW'(s_i);
      m_q   <= -PW'(s_i);
      r_q   <= PW'(sq_i) <<< (2 * FRAC + 2);
    end
  end

  assign ctl_w[0].vld = vld_q;
  assign ctl_w[0].neg = neg_q;
  assign q_w[0] = '0;
  assign p_w[0] = p_q;
  assign m_w[0] = m_q;
  assign r_w[0] = r_q;
  assign s_w[0] = s_q;

  // One stage per result bit, most significant first
  for (genvar j = 0; j < NS; j++) begin : g_stage
    vn_search_stage #(
      .FRAC (FRAC),
      .BIT  (FRAC - j),
      .PW   (PW)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .ctl_i  (ctl_w[j]),
      .q_i    (q_w[j]),
      .p_i    (p_w[j]),
      .m_i    (m_w[j]),
      .r_i    (r_w[j]),
      .s_i    (s_w[j]),
      .ctl_o  (ctl_w[j+1]),
      .q_o    (q_w[j+1]),
      .p_o    (p_w[j+1]),
      .m_o    (m_w[j+1]),
      .r_o    (r_w[j+1]),
      .s_o    (s_w[j+1])
    );
  end

  assign ctl_o = ctl_w[NS];
  assign q_o   = q_w[NS];
  assign s_o   = s_w[NS];

endmodule

/* verif/tb_top.sv */
module tb_top;

  localparam int unsigned OutFrac  = 30;
  localparam int unsigned Latency  = OutFrac + 5;
  localparam int unsigned LimitCyc = 200000;
  localparam int unsigned NumRand  = 1700;

  // One expected normalized vector
  typedef struct {
    logic signed [vn_pkg::CompW-1:0] ux, uy, uz;
    logic [vn_pkg::SqW-1:0]          len_sq;
    logic                            zero;
  } unit_vec_t;

  // Scoreboard: predicts each normalized vector and checks the results in order
  class norm_scoreboard;
    unit_vec_t expected_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned zero_seen;

    function automatic logic [32:0] magnitude(logic [vn_pkg::CompW-1:0] v);
      return v[vn_pkg::CompW-1] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    endfunction

    // round(|v| * 2^OutFrac / sqrt(s)), ties away from zero, by binary search
    function automatic logic [vn_pkg::CompW-1:0] scale_axis(logic [vn_pkg::CompW-1:0] v,
                                                           logic [vn_pkg::SqW-1:0] s);
      logic [32:0]  a;
      logic [127:0] rhs;
      logic [127:0] lhs;
      logic [63:0]  lo, hi, mid, odd;
      a   = magnitude(v);
      rhs = {64'd0, 64'(a) * 64'(a)} << (2 * OutFrac + 2);
      lo  = 0;
      hi  = 64'd1 << OutFrac;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        odd = 2 * mid - 1;
        lhs = {64'd0, odd * odd} * {64'd0, s};
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      if (lo > (64'd1 << OutFrac)) lo = 64'd1 << OutFrac;
      if (v[vn_pkg::CompW-1]) lo = -lo;
      return lo[vn_pkg::CompW-1:0];
    endfunction

    function void note_input(logic [vn_pkg::CompW-1:0] x, y, z);
      unit_vec_t e;
      logic [32:0] ax, ay, az;
      ax = magnitude(x);
      ay = magnitude(y);
      az = magnitude(z);
      e.len_sq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay) + 64'(az) * 64'(az);
      e.zero   = (e.len_sq == 0);
      if (e.zero) begin
        e.ux = '0; e.uy = '0; e.uz = '0;
      end else begin
        e.ux = scale_axis(x, e.len_sq);
        e.uy = scale_axis(y, e.len_sq);
        e.uz = scale_axis(z, e.len_sq);
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(unit_vec_t got);
      unit_vec_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result transfer");
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (e.zero) zero_seen++;
      if (got.ux !== e.ux || got.uy !== e.uy || got.uz !== e.uz ||
          got.len_sq !== e.len_sq || got.zero !== e.zero) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: exp u=(%0d %0d %0d) sq=%h z=%b got u=(%0d %0d %0d) sq=%h z=%b",
                   e.ux, e.uy, e.uz, e.len_sq, e.zero,
                   got.ux, got.uy, got.uz, got.len_sq, got.zero);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic signed [vn_pkg::CompW-1:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic signed [vn_pkg::CompW-1:0] unit_x_o, unit_y_o, unit_z_o;
  logic [vn_pkg::SqW-1:0]          length_squared_o;
  logic                            zero_length_o;

  norm_scoreboard sb = new();
  int unsigned send_idle_pct = 15;
  int unsigned recv_stall_pct = 62;
  int unsigned hold_cycles = 0;
  int unsigned cycle_cnt = 0;
  int unsigned sent_cnt = 0;

  vector3_normalizer #(.OUT_FRAC_BITS(OutFrac)) uut (.*);

  always #6 clk_i = ~clk_i;

  // Input transfers feed the predictor
  always @(posedge clk_i)
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_input(vec_x_i, vec_y_i, vec_z_i);

  // Output transfers are checked against the oldest prediction
  always @(posedge clk_i) begin
    unit_vec_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.ux = unit_x_o; got.uy = unit_y_o; got.uz = unit_z_o;
      got.len_sq = length_squared_o; got.zero = zero_length_o;
      sb.check_result(got);
    end
  end

  // Receiver stall: random, or a long counted hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i = 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LimitCyc) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_vec(logic [vn_pkg::CompW-1:0] x, y, z);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    vec_x_i = x; vec_y_i = y; vec_z_i = z;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [vn_pkg::CompW-1:0] rand_comp(int unsigned mode);
    case (mode)
      0: return $urandom();
      1: return vn_pkg::CompW'($signed($urandom_range(0, 4000)) - 2000);
      2: case ($urandom_range(0, 4))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'h0000_0001;
           3: return 32'hffff_ffff;
           default: return '0;
         endcase
      default: return $urandom() >>> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic send_random();
    int unsigned mode, axis;
    logic [vn_pkg::CompW-1:0] x, y, z;
    mode = $urandom_range(0, 3);
    x = rand_comp(mode); y = rand_comp(mode); z = rand_comp(mode);
    axis = $urandom_range(0, 9);
    // some vectors along one axis or in one plane, some all zero
    if (axis == 0) begin y = '0; z = '0; end
    else if (axis == 1) x = '0;
    else if (axis == 2) begin x = '0; y = '0; z = '0; end
    send_vec(x, y, z);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero, extremes, single axes, equal components
    send_vec('0, '0, '0);
    send_vec(32'h8000_0000, '0, '0);
    send_vec('0, 32'h8000_0000, '0);
    send_vec('0, '0, 32'h8000_0000);
    send_vec(32'h7fff_ffff, '0, '0);
    send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vec(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_vec(32'd1, '0, '0);
    send_vec(32'hffff_ffff, '0, '0);
    send_vec(32'd1, 32'd1, 32'd1);
    send_vec(32'hffff_ffff, 32'd1, 32'hffff_ffff);
    send_vec(32'd3, 32'd4, '0);
    send_vec(32'd2, 32'hffff_fffe, 32'd1);
    send_vec(32'h0001_0000, 32'h0001_0000, '0);
    send_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
    send_vec('0, '0, 32'd1);
    send_vec('0, '0, '0);
    drain();

    for (int i = 0; i < NumRand; i++) begin
      if (i == NumRand / 3) begin send_idle_pct = 62; recv_stall_pct = 15; end
      if (i == 2 * NumRand / 3) begin send_idle_pct = 0; recv_stall_pct = 0; end
      if (i == 2 * NumRand / 3 + 50) hold_cycles = 200;
      if (i == NumRand / 2) drain();
      send_random();
    end
    drain();
    repeat (Latency + 10) @(posedge clk_i);

    $display("Sent %0d vectors, checked %0d results (%0d zero-length).",
             sent_cnt, sb.checked, sb.zero_seen);
    $display("Covered extremes, single axes, stalls, a long back-pressure hold and drains.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
